@@ rtl/bptmm_pkg.sv @@
// Shared types, codes and helper functions of the block page table miss mapper.
package bptmm_pkg;

	localparam int ENTRY_W = 31;
	localparam int COORD_W = 10;
	localparam int CNT_W = 4;
	localparam int SIZE_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [COORD_W-1:0] COORD_MAX = 10'h3FF;
	// Unmapped entry: flag clear, coordinates all ones.
	localparam logic [ENTRY_W-1:0] UNMAPPED_ENTRY = 31'h3FFF_FFFF;

	typedef enum logic {
		OP_MAP = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHYS_BLOCKS_X = 3'd0,
		REG_PHYS_BLOCKS_Y = 3'd1,
		REG_PHYS_BLOCKS_Z = 3'd2,
		REG_PAGE_SIZE_X = 3'd3,
		REG_PAGE_SIZE_Y = 3'd4,
		REG_PAGE_SIZE_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic clr_wr;
		logic acc_map;
		logic acc_look;
		logic map_fire;
		logic look_fire;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
	} stat_t;

	// Effective slot count minus one: zero acts as one, large counts clip to the maximum.
	function automatic logic [CNT_W-1:0] eff_m1(input logic [CNT_W-1:0] v,
			input logic [CNT_W:0] max_slots);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if ({1'b0, v} > max_slots) begin
			r = CNT_W'(max_slots - 5'd1);
		end else begin
			r = v - 4'd1;
		end
		return r;
	endfunction

	// Voxel origin of a slot coordinate, saturated to the coordinate range.
	function automatic logic [COORD_W-1:0] origin(input logic [CNT_W-1:0] slot,
			input logic [SIZE_W-1:0] page);
		logic [CNT_W+SIZE_W-1:0] p;
		p = {{SIZE_W{1'b0}}, slot} * {{CNT_W{1'b0}}, page};
		return (p > {2'b00, COORD_MAX}) ? COORD_MAX : p[COORD_W-1:0];
	endfunction

endpackage

@@ rtl/block_page_table_miss_mapper.sv @@
// Top level of the block page table miss mapper: controller plus datapath.
// A map or lookup is accepted in the idle state and finishes in its own state. In the accept
// cycle a map writes the new entry into the page table and reads the slot owner, and a lookup
// reads its entry. On finishing, the result register is loaded and, for a map, the slot owner
// is written and, once every slot has an owner, the slot's previous owner is unmapped through
// the page table's single write port. No new transaction is taken before the last finishes.
// The result register lets a new transaction be accepted while the last result still waits
// downstream; a transaction finishes only once that register is free, so output stall can
// hold it. After reset all VIRT_DIM cubed page table entries (4096 by default) are swept clear,
// one entry a cycle, with in_stall high; configuration writes are taken during the sweep.
module block_page_table_miss_mapper #(
	parameter int VIRT_DIM = 16,
	parameter int MAX_SLOTS_PER_AXIS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bptmm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bptmm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               opcode,
	input  logic [3:0]                         virt_x,
	input  logic [3:0]                         virt_y,
	input  logic [3:0]                         virt_z,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               is_mapped,
	output logic [bptmm_pkg::COORD_W-1:0]      phys_x,
	output logic [bptmm_pkg::COORD_W-1:0]      phys_y,
	output logic [bptmm_pkg::COORD_W-1:0]      phys_z
);

	bptmm_pkg::cmd_t cmd;
	bptmm_pkg::stat_t stat;

	bptmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bptmm_dp #(
		.VIRT_DIM           (VIRT_DIM),
		.MAX_SLOTS_PER_AXIS (MAX_SLOTS_PER_AXIS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.virt_x    (virt_x),
		.virt_y    (virt_y),
		.virt_z    (virt_z),
		.cmd       (cmd),
		.stat      (stat),
		.is_mapped (is_mapped),
		.phys_x    (phys_x),
		.phys_y    (phys_y),
		.phys_z    (phys_z)
	);

endmodule

@@ rtl/bptmm_ctrl.sv @@
// Controller: clear sweep, transaction acceptance and result handoff sequencing.
module bptmm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 opcode,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  bptmm_pkg::stat_t     stat,
	output bptmm_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP,
		ST_LOOK
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				cmd.acc_map = in_valid && (opcode == bptmm_pkg::OP_MAP);
				cmd.acc_look = in_valid && (opcode == bptmm_pkg::OP_LOOKUP);
			end
			ST_MAP: cmd.map_fire = out_free;
			ST_LOOK: cmd.look_fire = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: if (stat.clr_last) state_q <= ST_IDLE;
				ST_IDLE: begin
					if (cmd.acc_map) state_q <= ST_MAP;
					else if (cmd.acc_look) state_q <= ST_LOOK;
				end
				ST_MAP: if (cmd.map_fire) state_q <= ST_IDLE;
				ST_LOOK: if (cmd.look_fire) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			// hold the result until it is taken downstream
			if (cmd.map_fire || cmd.look_fire) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	a_map_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_map |=> (state_q == ST_MAP))
		else $error("map transaction did not enter map state");

	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.map_fire || cmd.look_fire))
		else $error("result appeared without a fire");

	a_no_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !(cmd.acc_map || cmd.acc_look))
		else $error("transaction accepted during clear sweep");

endmodule

@@ rtl/bptmm_dp.sv @@
// Datapath: configuration, victim walk, page table and slot owner memories, result register.
module bptmm_dp #(
	parameter int VIRT_DIM = 16,
	parameter int MAX_SLOTS_PER_AXIS = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [bptmm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bptmm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic [3:0]                              virt_x,
	input  logic [3:0]                              virt_y,
	input  logic [3:0]                              virt_z,
	input  bptmm_pkg::cmd_t                         cmd,
	output bptmm_pkg::stat_t                        stat,
	output logic                                    is_mapped,
	output logic [bptmm_pkg::COORD_W-1:0]           phys_x,
	output logic [bptmm_pkg::COORD_W-1:0]           phys_y,
	output logic [bptmm_pkg::COORD_W-1:0]           phys_z
);

	localparam int NUM_ENTRIES = VIRT_DIM * VIRT_DIM * VIRT_DIM;
	localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int NUM_SLOTS = MAX_SLOTS_PER_AXIS * MAX_SLOTS_PER_AXIS * MAX_SLOTS_PER_AXIS;
	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int VW = (MAX_SLOTS_PER_AXIS > 1) ? $clog2(MAX_SLOTS_PER_AXIS) : 1;
	localparam logic [bptmm_pkg::CNT_W:0] MAX_S = 5'(MAX_SLOTS_PER_AXIS);
	localparam logic [VW-1:0] VIC_RST = VW'(((MAX_SLOTS_PER_AXIS < 8) ?
		MAX_SLOTS_PER_AXIS : 8) - 1);
	localparam logic [3:0] VIRT_TOP = 4'(VIRT_DIM - 1);
	localparam int EW = bptmm_pkg::ENTRY_W;
	localparam int CW = bptmm_pkg::COORD_W;

	logic [bptmm_pkg::CNT_W-1:0] pbx_q, pby_q, pbz_q;
	logic [bptmm_pkg::SIZE_W-1:0] psx_q, psy_q, psz_q;
	logic [VW-1:0] victim_x_q, victim_y_q, victim_z_q;
	logic wrapped_q;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] owner_rd_q;
	logic [EW-1:0] page_rd_q;
	logic is_mapped_q;
	logic [CW-1:0] phys_x_q, phys_y_q, phys_z_q;

	logic [EW-1:0] page_mem [NUM_ENTRIES];
	logic [IDX_W-1:0] owner_mem [NUM_SLOTS];

	logic [3:0] vx_c, vy_c, vz_c;
	logic [IDX_W-1:0] idx_c;
	logic [SLOT_W-1:0] slot_c;
	logic [CW-1:0] ox_c, oy_c, oz_c;
	logic [bptmm_pkg::CNT_W-1:0] nbx_c, nby_c, nbz_c;
	logic cfg_hit;
	logic page_we;
	logic [IDX_W-1:0] page_wa;
	logic [EW-1:0] page_wd;

	assign vx_c = (7'(virt_x) >= 7'(VIRT_DIM)) ? VIRT_TOP : virt_x;
	assign vy_c = (7'(virt_y) >= 7'(VIRT_DIM)) ? VIRT_TOP : virt_y;
	assign vz_c = (7'(virt_z) >= 7'(VIRT_DIM)) ? VIRT_TOP : virt_z;
	assign idx_c = IDX_W'(32'(vz_c) * VIRT_DIM * VIRT_DIM + 32'(vy_c) * VIRT_DIM
		+ 32'(vx_c));
	assign slot_c = SLOT_W'((32'(victim_z_q) * MAX_SLOTS_PER_AXIS + 32'(victim_y_q))
		* MAX_SLOTS_PER_AXIS + 32'(victim_x_q));

	assign ox_c = bptmm_pkg::origin(4'(victim_x_q), psx_q);
	assign oy_c = bptmm_pkg::origin(4'(victim_y_q), psy_q);
	assign oz_c = bptmm_pkg::origin(4'(victim_z_q), psz_q);

	assign stat.clr_last = (clr_q == IDX_W'(NUM_ENTRIES - 1));

	// Slot counts after this write, for reloading the victim walk.
	assign cfg_hit = cfg_we && (cfg_index <= bptmm_pkg::REG_PAGE_SIZE_Z);
	assign nbx_c = (cfg_index == bptmm_pkg::REG_PHYS_BLOCKS_X) ? cfg_wdata[3:0] : pbx_q;
	assign nby_c = (cfg_index == bptmm_pkg::REG_PHYS_BLOCKS_Y) ? cfg_wdata[3:0] : pby_q;
	assign nbz_c = (cfg_index == bptmm_pkg::REG_PHYS_BLOCKS_Z) ? cfg_wdata[3:0] : pbz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbx_q <= 4'd8;
			pby_q <= 4'd8;
			pbz_q <= 4'd8;
			psx_q <= 8'd64;
			psy_q <= 8'd64;
			psz_q <= 8'd64;
			victim_x_q <= VIC_RST;
			victim_y_q <= VIC_RST;
			victim_z_q <= VIC_RST;
			wrapped_q <= 1'b0;
			clr_q <= '0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			priority if (cfg_hit) begin
				unique case (cfg_index)
					bptmm_pkg::REG_PHYS_BLOCKS_X: pbx_q <= cfg_wdata[3:0];
					bptmm_pkg::REG_PHYS_BLOCKS_Y: pby_q <= cfg_wdata[3:0];
					bptmm_pkg::REG_PHYS_BLOCKS_Z: pbz_q <= cfg_wdata[3:0];
					bptmm_pkg::REG_PAGE_SIZE_X: psx_q <= cfg_wdata;
					bptmm_pkg::REG_PAGE_SIZE_Y: psy_q <= cfg_wdata;
					bptmm_pkg::REG_PAGE_SIZE_Z: psz_q <= cfg_wdata;
					default: ;
				endcase
				// restart the victim walk with every slot free
				victim_x_q <= VW'(bptmm_pkg::eff_m1(nbx_c, MAX_S));
				victim_y_q <= VW'(bptmm_pkg::eff_m1(nby_c, MAX_S));
				victim_z_q <= VW'(bptmm_pkg::eff_m1(nbz_c, MAX_S));
				wrapped_q <= 1'b0;
			end else if (cmd.map_fire) begin
				if (victim_x_q != '0) begin
					victim_x_q <= victim_x_q - 1'b1;
				end else begin
					victim_x_q <= VW'(bptmm_pkg::eff_m1(pbx_q, MAX_S));
					if (victim_y_q != '0) begin
						victim_y_q <= victim_y_q - 1'b1;
					end else begin
						victim_y_q <= VW'(bptmm_pkg::eff_m1(pby_q, MAX_S));
						if (victim_z_q != '0) begin
							victim_z_q <= victim_z_q - 1'b1;
						end else begin
							// every slot now has an owner
							victim_z_q <= VW'(bptmm_pkg::eff_m1(pbz_q, MAX_S));
							wrapped_q <= 1'b1;
						end
					end
				end
			end else begin
				// hold the victim walk
				wrapped_q <= wrapped_q;
			end
		end
	end

	// One write port: clear sweep, new entry on map, previous owner unmap on fire once wrapped.
	always_comb begin
		page_we = 1'b0;
		page_wa = clr_q;
		page_wd = bptmm_pkg::UNMAPPED_ENTRY;
		priority if (cmd.clr_wr) begin
			page_we = 1'b1;
		end else if (cmd.acc_map) begin
			page_we = 1'b1;
			page_wa = idx_c;
			page_wd = {1'b1, ox_c, oy_c, oz_c};
		end else if (cmd.map_fire && wrapped_q) begin
			page_we = 1'b1;
			page_wa = owner_rd_q;
		end else begin
			page_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (page_we) page_mem[page_wa] <= page_wd;
		if (cmd.acc_look) page_rd_q <= page_mem[idx_c];
	end

	always_ff @(posedge clk) begin
		if (cmd.map_fire) owner_mem[slot_c] <= idx_q;
		if (cmd.acc_map) owner_rd_q <= owner_mem[slot_c];
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_map) idx_q <= idx_c;
		if (cmd.map_fire) begin
			is_mapped_q <= 1'b1;
			phys_x_q <= ox_c;
			phys_y_q <= oy_c;
			phys_z_q <= oz_c;
		end else if (cmd.look_fire) begin
			is_mapped_q <= page_rd_q[EW-1];
			phys_x_q <= page_rd_q[3*CW-1:2*CW];
			phys_y_q <= page_rd_q[2*CW-1:CW];
			phys_z_q <= page_rd_q[CW-1:0];
		end
	end

	assign is_mapped = is_mapped_q;
	assign phys_x = phys_x_q;
	assign phys_y = phys_y_q;
	assign phys_z = phys_z_q;

	a_victim_range: assert property (@(posedge clk) disable iff (!arst_n)
		(victim_x_q <= VW'(bptmm_pkg::eff_m1(pbx_q, MAX_S)))
		&& (victim_y_q <= VW'(bptmm_pkg::eff_m1(pby_q, MAX_S)))
		&& (victim_z_q <= VW'(bptmm_pkg::eff_m1(pbz_q, MAX_S))))
		else $error("victim slot outside configured grid");

	a_wrap_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(wrapped_q) |-> $past(cmd.map_fire))
		else $error("slot walk wrapped without a map");

	a_map_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.map_fire |=> is_mapped_q)
		else $error("map result not flagged mapped");

endmodule
